// ===== design/hbsf_pkg.sv =====
// package for the hdlc bit stuffing framer
// shared constants, queue entry type and front/back control structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hbsf_pkg;

    localparam int RUN_LIMIT   = 5;
    localparam int RUN_W       = 3;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam int FLAG_LEN    = 8;
    localparam int IDX_W       = $clog2(FLAG_LEN);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_STUFF   = 1'b0;
    localparam logic MODE_DESTUFF = 1'b1;

    typedef struct packed {
        logic data;
        logic pre_flag;
        logic stuff_zero;
        logic post_flag;
    } desc_t;

    typedef struct packed {
        logic  push;
        desc_t desc;
    } q_wr_t;

    typedef struct packed {
        logic  valid;
        desc_t desc;
    } q_rd_t;

endpackage

`default_nettype wire

// ===== design/hbsf_if.sv =====
// channel interfaces for the hdlc bit stuffing framer
// input bits, output bits and mode write channel; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface hbsf_in_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic first_bit;
    logic last_bit;

    modport source (output valid, output data_bit, output first_bit, output last_bit,
                    input ready);
    modport sink (input valid, input data_bit, input first_bit, input last_bit,
                  output ready);
endinterface

interface hbsf_out_if;
    logic valid;
    logic ready;
    logic out_bit;
    logic run_last;

    modport source (output valid, output out_bit, output run_last, input ready);
    modport sink (input valid, input out_bit, input run_last, output ready);
endinterface

interface hbsf_cfg_if;
    logic valid;
    logic ready;
    logic mode;

    modport source (output valid, output mode, input ready);
    modport sink (input valid, input mode, output ready);
endinterface

`default_nettype wire

// ===== design/hbsf_front.sv =====
// front end: accepts frame bits, tracks the ones run and the mode register
// builds one queue entry per bit that produces output; uses hbsf_pkg, hbsf_if
`timescale 1ns / 1ps
`default_nettype none

module hbsf_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    hbsf_in_if.sink            din,
    hbsf_cfg_if.sink           cfg,
    input  wire logic          q_full,
    output hbsf_pkg::q_wr_t    q_wr
);

    logic                       mode_reg;
    logic [hbsf_pkg::RUN_W-1:0] ones_run_reg;
    logic [hbsf_pkg::RUN_W-1:0] ones_run_next;
    logic                       skip_reg;
    logic                       skip_next;

    logic                       accept;
    logic                       cfg_write;
    logic                       emit;
    logic                       hit;
    logic [hbsf_pkg::RUN_W-1:0] run_start;
    logic [hbsf_pkg::RUN_W-1:0] run_inc;
    logic                       skip_start;
    hbsf_pkg::desc_t            desc;

    assign din.ready = !q_full;
    assign cfg.ready = 1'b1;
    assign accept    = din.valid && din.ready;
    assign cfg_write = cfg.valid && cfg.ready;

    always_comb
    begin
        run_start  = din.first_bit ? '0 : ones_run_reg;
        skip_start = din.first_bit ? 1'b0 : skip_reg;
        run_inc    = din.data_bit ? run_start + 1'b1 : '0;
        hit        = (run_inc == hbsf_pkg::RUN_W'(hbsf_pkg::RUN_LIMIT));

        desc.data       = din.data_bit;
        desc.pre_flag   = 1'b0;
        desc.stuff_zero = 1'b0;
        desc.post_flag  = 1'b0;

        if (mode_reg == hbsf_pkg::MODE_STUFF)
        begin
            emit            = 1'b1;
            desc.pre_flag   = din.first_bit;
            desc.stuff_zero = hit;
            desc.post_flag  = din.last_bit;
            ones_run_next   = hit ? '0 : run_inc;
            skip_next       = skip_start;
        end
        else if (skip_start)
        begin
            // bit after a full run is dropped
            emit          = 1'b0;
            ones_run_next = '0;
            skip_next     = 1'b0;
        end
        else
        begin
            emit          = 1'b1;
            ones_run_next = hit ? '0 : run_inc;
            skip_next     = hit;
        end

        if (din.last_bit)
        begin
            ones_run_next = '0;
            skip_next     = 1'b0;
        end
    end

    assign q_wr.push = accept && emit;
    assign q_wr.desc = desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= hbsf_pkg::MODE_STUFF;
            ones_run_reg <= '0;
            skip_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            mode_reg     <= cfg.mode;
            ones_run_reg <= '0;
            skip_reg     <= 1'b0;
        end
        else if (accept)
        begin
            ones_run_reg <= ones_run_next;
            skip_reg     <= skip_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/hbsf_queue.sv =====
// short queue of bit descriptors between front and back end
// uses hbsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module hbsf_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hbsf_pkg::q_wr_t q_wr,
    output logic               q_full,
    input  wire logic          q_pop,
    output hbsf_pkg::q_rd_t    q_rd
);

    hbsf_pkg::desc_t             entry_reg [hbsf_pkg::QUEUE_DEPTH];
    logic [hbsf_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [hbsf_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [hbsf_pkg::QCNT_W-1:0] count_reg;

    localparam logic [hbsf_pkg::QPTR_W-1:0] PTR_LAST =
        hbsf_pkg::QPTR_W'(hbsf_pkg::QUEUE_DEPTH - 1);

    assign q_full     = (count_reg == hbsf_pkg::QCNT_W'(hbsf_pkg::QUEUE_DEPTH));
    assign q_rd.valid = (count_reg != '0);
    assign q_rd.desc  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            entry_reg[wr_ptr_reg] <= q_wr.desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_wr.push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (q_wr.push && !q_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (q_pop && !q_wr.push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/hbsf_back.sv =====
// back end: serializes one descriptor into flag, data and stuffed bits
// a registered output bit per cycle unless stalled; uses hbsf_pkg, hbsf_if
`timescale 1ns / 1ps
`default_nettype none

module hbsf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hbsf_pkg::q_rd_t q_rd,
    output logic               q_pop,
    hbsf_out_if.source         dout
);

    localparam int          PH_W     = 3;
    localparam logic [PH_W-1:0] PH_START = 3'd0;
    localparam logic [PH_W-1:0] PH_PRE   = 3'd1;
    localparam logic [PH_W-1:0] PH_DATA  = 3'd2;
    localparam logic [PH_W-1:0] PH_STUFF = 3'd3;
    localparam logic [PH_W-1:0] PH_POST  = 3'd4;

    localparam logic [hbsf_pkg::IDX_W-1:0] IDX_TOP =
        hbsf_pkg::IDX_W'(hbsf_pkg::FLAG_LEN - 1);

    logic [PH_W-1:0]            phase_reg;
    logic [PH_W-1:0]            phase_next;
    logic [hbsf_pkg::IDX_W-1:0] idx_reg;
    logic [hbsf_pkg::IDX_W-1:0] idx_next;
    logic                       out_valid_reg;
    logic                       out_bit_reg;
    logic                       run_last_reg;

    logic [PH_W-1:0]            cur_phase;
    logic                       bit_val;
    logic                       done;
    logic                       advance;

    assign cur_phase = (phase_reg == PH_START) ?
                       (q_rd.desc.pre_flag ? PH_PRE : PH_DATA) : phase_reg;

    always_comb
    begin
        bit_val    = 1'b0;
        done       = 1'b0;
        phase_next = cur_phase;
        idx_next   = idx_reg;
        case (cur_phase)
            PH_PRE:
            begin
                bit_val = hbsf_pkg::FLAG_BYTE[idx_reg];
                if (idx_reg == '0)
                begin
                    phase_next = PH_DATA;
                    idx_next   = IDX_TOP;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            PH_DATA:
            begin
                bit_val = q_rd.desc.data;
                if (q_rd.desc.stuff_zero)
                begin
                    phase_next = PH_STUFF;
                end
                else if (q_rd.desc.post_flag)
                begin
                    phase_next = PH_POST;
                    idx_next   = IDX_TOP;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            PH_STUFF:
            begin
                bit_val = 1'b0;
                if (q_rd.desc.post_flag)
                begin
                    phase_next = PH_POST;
                    idx_next   = IDX_TOP;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            PH_POST:
            begin
                bit_val = hbsf_pkg::FLAG_BYTE[idx_reg];
                if (idx_reg == '0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
        if (done)
        begin
            phase_next = PH_START;
            idx_next   = IDX_TOP;
        end
    end

    assign advance    = q_rd.valid && (!out_valid_reg || dout.ready);
    assign q_pop      = advance && done;
    assign dout.valid    = out_valid_reg;
    assign dout.out_bit  = out_bit_reg;
    assign dout.run_last = run_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            idx_reg       <= IDX_TOP;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_bit_reg  <= bit_val;
            run_last_reg <= done;
        end
    end

endmodule

`default_nettype wire

// ===== design/hdlc_bit_stuff_framer.sv =====
// hdlc bit stuffing framer: input bits pass through the queue, then the output register
// output: one bit per cycle unless stalled, from the back end serializer's output register
// an input bit gives its data bit plus any flags and stuffed zero; dropped bits give none
// input accepts while the two-entry queue has room
// reset clears mode to stuff, run count, pending drop, queue and output valid
// top level; uses hbsf_pkg, hbsf_if, hbsf_front, hbsf_queue, hbsf_back
`timescale 1ns / 1ps
`default_nettype none

module hdlc_bit_stuff_framer (
    input  wire logic clk,
    input  wire logic rst_n,
    hbsf_in_if.sink   din,
    hbsf_cfg_if.sink  cfg,
    hbsf_out_if.source dout
);

    hbsf_pkg::q_wr_t q_wr;
    hbsf_pkg::q_rd_t q_rd;
    logic            q_full;
    logic            q_pop;

    hbsf_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .din    (din),
        .cfg    (cfg),
        .q_full (q_full),
        .q_wr   (q_wr)
    );

    hbsf_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_pop  (q_pop),
        .q_rd   (q_rd)
    );

    hbsf_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .q_rd  (q_rd),
        .q_pop (q_pop),
        .dout  (dout)
    );

endmodule

`default_nettype wire

// ===== design/hbsf_checker.sv =====
// port level checks for the hdlc bit stuffing framer
// bound to hdlc_bit_stuff_framer; no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module hbsf_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic dout_valid,
    input wire logic dout_ready,
    input wire logic out_bit,
    input wire logic run_last
);

    // stalled output holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |=> dout_valid && $stable(out_bit) && $stable(run_last))
        else $error("output changed while stalled");

    // a bit that is not the last of its input transaction is followed at once
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && dout_ready && !run_last |=> dout_valid)
        else $error("gap inside the bits of one input transaction");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !dout_valid)
        else $error("output valid right after reset");

endmodule

bind hdlc_bit_stuff_framer hbsf_checker u_hbsf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .dout_valid (dout.valid),
    .dout_ready (dout.ready),
    .out_bit    (dout.out_bit),
    .run_last   (dout.run_last)
);

`default_nettype wire
